// ----- design/asi_pkg.sv -----
`timescale 1ns / 1ps

package asi_pkg;

	// Sizes
	localparam int CountW     = 12;
	localparam int StreamW    = 3;
	localparam int ModeW      = 5;
	localparam int CfgIndexW  = 2;
	localparam int CfgDataW   = 12;

	localparam logic [StreamW-1:0] MAX_STREAMS = 3'd4;

	localparam logic [CountW-1:0] ARM_TICKS_RST  = 12'd3000;
	localparam logic [CountW-1:0] LIVE_TICKS_RST = 12'd500;

	// Event modes
	localparam logic [ModeW-1:0] MODE_TICK       = 5'd0;
	localparam logic [ModeW-1:0] MODE_GATE_OPEN  = 5'd1;
	localparam logic [ModeW-1:0] MODE_GATE_REL   = 5'd2;
	localparam logic [ModeW-1:0] MODE_ARM        = 5'd3;
	localparam logic [ModeW-1:0] MODE_UNMUTE     = 5'd4;
	localparam logic [ModeW-1:0] MODE_SAFE       = 5'd5;
	localparam logic [ModeW-1:0] MODE_KEEPALIVE  = 5'd6;
	localparam logic [ModeW-1:0] MODE_DAC_MUTE   = 5'd7;
	localparam logic [ModeW-1:0] MODE_LINE_28DB  = 5'd12;
	localparam logic [ModeW-1:0] MODE_STARTUP    = 5'd13;
	localparam logic [ModeW-1:0] MODE_PREPARE    = 5'd14;
	localparam logic [ModeW-1:0] MODE_TRIGGER    = 5'd15;
	localparam logic [ModeW-1:0] MODE_FREE       = 5'd16;
	localparam logic [ModeW-1:0] MODE_SHUTDOWN   = 5'd17;
	localparam logic [ModeW-1:0] MODE_UNKNOWN    = 5'd18;
	localparam logic [ModeW-1:0] MODE_REMOVE     = 5'd19;

	// Trigger kinds
	localparam logic [1:0] TRIG_START = 2'd0;
	localparam logic [1:0] TRIG_STOP  = 2'd1;

	// Status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_BUSY    = 3'd1;
	localparam logic [2:0] ST_PERM    = 3'd2;
	localparam logic [2:0] ST_UNKNOWN = 3'd3;
	localparam logic [2:0] ST_BADTRIG = 3'd4;

	localparam logic [2:0] ACT_NONE = 3'd0;

	// Configuration register indexes
	localparam logic [CfgIndexW-1:0] REG_GATES_PRESENT = 2'd0;
	localparam logic [CfgIndexW-1:0] REG_CODEC_PRESENT = 2'd1;
	localparam logic [CfgIndexW-1:0] REG_ARM_TICKS     = 2'd2;
	localparam logic [CfgIndexW-1:0] REG_LIVE_TICKS    = 2'd3;

	typedef struct packed {
		logic [ModeW-1:0] mode;
		logic             is_playback;
		logic             caller_is_owner;
		logic             caller_privileged;
		logic [1:0]       trigger_kind;
	} asi_evt_t;

	typedef struct packed {
		logic [2:0] status;
		logic       enable_gate;
		logic       unmute_gate;
		logic       playing;
		logic [2:0] codec_action;
		logic       timeout_fired;
	} asi_res_t;

	typedef struct packed {
		logic              gates_present;
		logic              codec_present;
		logic [CountW-1:0] arm_ticks;
		logic [CountW-1:0] live_ticks;
	} asi_cfg_t;

	typedef struct packed {
		logic               shdn_released;
		logic               mute_released;
		logic               play_active;
		logic               play_open;
		logic               play_diagnostic;
		logic               gate_held;
		logic [StreamW-1:0] stream_count;
		logic [CountW-1:0]  countdown;
		logic               countdown_running;
	} asi_state_t;

endpackage

// ----- design/asi_step.sv -----
`timescale 1ns / 1ps

// Next-state and result logic for one event
module asi_step import asi_pkg::*; (
	input  asi_evt_t   evt,
	input  asi_cfg_t   cfg,
	input  asi_state_t cur,
	output asi_state_t nxt,
	output asi_res_t   res
);

	logic [2:0] status;
	logic [2:0] action;
	logic       fired;
	asi_state_t s;

	// Mute, shut down and end playback; no effect without gates
	function automatic asi_state_t force_safe(asi_state_t st, logic gp);
		asi_state_t r;
		r = st;
		if (gp) begin
			r.mute_released = 1'b0;
			r.shdn_released = 1'b0;
			r.play_active = 1'b0;
		end
		return r;
	endfunction

	function automatic asi_state_t stop_cd(asi_state_t st);
		asi_state_t r;
		r = st;
		r.countdown = '0;
		r.countdown_running = 1'b0;
		return r;
	endfunction

	function automatic asi_state_t load_cd(asi_state_t st, logic [CountW-1:0] ticks);
		asi_state_t r;
		r = st;
		r.countdown = ticks;
		r.countdown_running = 1'b1;
		return r;
	endfunction

	always_comb begin
		s      = cur;
		status = ST_OK;
		action = ACT_NONE;
		fired  = 1'b0;
		unique case (evt.mode) inside
			MODE_TICK: begin
				if (s.countdown_running) begin
					if (s.countdown <= CountW'(1)) begin
						s = stop_cd(s);
						if (s.shdn_released || s.mute_released) begin
							s     = force_safe(s, cfg.gates_present);
							fired = 1'b1;
						end
					end else begin
						s.countdown = s.countdown - CountW'(1);
					end
				end
			end
			MODE_GATE_OPEN: begin
				if (!cfg.gates_present || !evt.caller_privileged) begin
					status = ST_PERM;
				end else if (s.gate_held) begin
					status = ST_BUSY;
				end else begin
					s = stop_cd(s);
					if (s.stream_count != '0) begin
						status = ST_BUSY;
					end else begin
						s = force_safe(s, cfg.gates_present);
						s.gate_held = 1'b1;
					end
				end
			end
			[MODE_GATE_REL:MODE_LINE_28DB], MODE_UNKNOWN: begin
				if (!cfg.gates_present || !s.gate_held) begin
					status = ST_PERM;
				end else begin
					case (evt.mode) inside
						MODE_GATE_REL: begin
							s = force_safe(stop_cd(s), cfg.gates_present);
							s.gate_held = 1'b0;
						end
						MODE_ARM: begin
							s = force_safe(stop_cd(s), cfg.gates_present);
							s.shdn_released = 1'b1;
							s = load_cd(s, cfg.arm_ticks);
						end
						MODE_UNMUTE: begin
							if (!s.shdn_released || s.mute_released) begin
								status = ST_PERM;
							end else begin
								s.mute_released = 1'b1;
								s = load_cd(s, cfg.live_ticks);
							end
						end
						MODE_SAFE: begin
							s = force_safe(stop_cd(s), cfg.gates_present);
						end
						MODE_KEEPALIVE: begin
							if (!s.mute_released) status = ST_PERM;
							else s = load_cd(s, cfg.live_ticks);
						end
						[MODE_DAC_MUTE:MODE_LINE_28DB]: begin
							if (!s.mute_released || !cfg.codec_present) begin
								status = ST_PERM;
							end else begin
								action = 3'(evt.mode - MODE_KEEPALIVE);
								s = load_cd(s, cfg.live_ticks);
							end
						end
						default: status = ST_UNKNOWN;
					endcase
				end
			end
			MODE_STARTUP: begin
				if (s.gate_held && !evt.caller_is_owner) begin
					status = ST_BUSY;
				end else if (s.stream_count >= MAX_STREAMS) begin
					status = ST_BUSY;
				end else if (evt.is_playback && s.play_open) begin
					status = ST_BUSY;
				end else begin
					if (evt.is_playback) begin
						s.play_open       = 1'b1;
						s.play_diagnostic = s.gate_held;
					end
					s.stream_count = s.stream_count + StreamW'(1);
				end
			end
			MODE_PREPARE: begin
				if (evt.is_playback && !s.play_diagnostic) begin
					if (s.gate_held) status = ST_BUSY;
					else s = force_safe(s, cfg.gates_present);
				end
			end
			MODE_TRIGGER: begin
				if (evt.is_playback && !s.play_diagnostic) begin
					if (evt.trigger_kind == TRIG_START) begin
						// Start playback: needs an open, non-diagnostic stream
						if (cfg.gates_present && !s.play_active) begin
							if (!s.play_open || s.gate_held) begin
								status = ST_BUSY;
							end else begin
								s.shdn_released = 1'b1;
								s.mute_released = 1'b1;
								s.play_active = 1'b1;
							end
						end
					end else if (evt.trigger_kind == TRIG_STOP) begin
						s = force_safe(s, cfg.gates_present);
					end else begin
						status = ST_BADTRIG;
					end
				end
			end
			MODE_FREE: begin
				if (evt.is_playback && !s.play_diagnostic)
					s = force_safe(s, cfg.gates_present);
			end
			MODE_SHUTDOWN: begin
				if (evt.is_playback) begin
					if (!s.play_diagnostic) s = force_safe(s, cfg.gates_present);
					s.play_open       = 1'b0;
					s.play_diagnostic = 1'b0;
				end
				if (s.stream_count != '0) s.stream_count = s.stream_count - StreamW'(1);
			end
			MODE_REMOVE: begin
				if (cfg.gates_present) s = force_safe(stop_cd(s), cfg.gates_present);
			end
			default: status = ST_UNKNOWN;
		endcase

		nxt               = s;
		res.status        = status;
		res.enable_gate   = s.shdn_released;
		res.unmute_gate   = s.mute_released;
		res.playing       = s.play_active;
		res.codec_action  = action;
		res.timeout_fired = fired;
	end

endmodule

// ----- design/amp_safety_interlock.sv -----
`timescale 1ns / 1ps

// Amplifier safety interlock.
// Event channel (evt, evt_valid, evt_stall): one word per timer tick, test-gate
// event or stream event. Result channel (res, res_valid, res_stall): one word
// per event, in order, carrying status, gate levels, codec action and the
// keepalive-expiry flag. Configuration (cfg_valid, cfg_ready, cfg_index,
// cfg_data) writes the four registers; cfg_ready is always high, and writes
// are expected only while no event is in flight.
// An accepted event lands in the input register, and its result is registered in
// the result register and then driven on res. One event per cycle while
// res_stall is low; the interlock state updates in a single pass between the
// two registers.
// When res_stall is held, the result register keeps its word and the input
// register can still take one more event; after that evt_stall rises.
// Reset (arst_n low) clears all gate levels, flags, the stream count and the
// countdown, empties both registers, and restores the configuration defaults
// (gates and codec present, arm timeout 3000 ticks, live timeout 500 ticks).
module amp_safety_interlock import asi_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  asi_evt_t             evt,
	input  logic                 evt_valid,
	output logic                 evt_stall,
	output asi_res_t             res,
	output logic                 res_valid,
	input  logic                 res_stall,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data
);

	asi_evt_t   evt_s1;
	logic       valid_s1;
	asi_res_t   res_q;
	logic       res_valid_q;
	asi_state_t state_q;
	asi_cfg_t   cfg_q;
	asi_state_t state_nxt;
	asi_res_t   res_nxt;
	logic       s1_move;
	logic       evt_take;

	// Handshake control
	assign s1_move   = valid_s1 && (!res_valid_q || !res_stall);
	assign evt_stall = valid_s1 && !s1_move;
	assign evt_take  = evt_valid && !evt_stall;
	assign cfg_ready = 1'b1;
	assign res       = res_q;
	assign res_valid = res_valid_q;

	asi_step u_step (
		.evt (evt_s1),
		.cfg (cfg_q),
		.cur (state_q),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	// Payload registers
	always_ff @(posedge clk) begin
		if (evt_take) evt_s1 <= evt;
		if (s1_move) res_q <= res_nxt;
	end

	// Control, state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			state_q     <= '0;
			cfg_q.gates_present <= 1'b1;
			cfg_q.codec_present <= 1'b1;
			cfg_q.arm_ticks     <= ARM_TICKS_RST;
			cfg_q.live_ticks    <= LIVE_TICKS_RST;
		end else begin
			if (evt_take) valid_s1 <= 1'b1;
			else if (s1_move) valid_s1 <= 1'b0;

			if (s1_move) begin
				res_valid_q <= 1'b1;
				state_q     <= state_nxt;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_GATES_PRESENT: cfg_q.gates_present <= cfg_data[0];
					REG_CODEC_PRESENT: cfg_q.codec_present <= cfg_data[0];
					REG_ARM_TICKS:     cfg_q.arm_ticks     <= cfg_data;
					REG_LIVE_TICKS:    cfg_q.live_ticks    <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- tb/sv/amp_safety_interlock_tb.sv -----
`timescale 1ns / 1ps

module amp_safety_interlock_tb;
	import asi_pkg::*;

	// Top of the mode field, never decoded by the block
	localparam logic [ModeW-1:0] MODE_UNUSED_TOP = 5'd31;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	asi_evt_t evt = '0;
	logic evt_valid = 1'b0;
	logic evt_stall;
	asi_res_t res;
	logic res_valid;
	logic res_stall = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIndexW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	amp_safety_interlock u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.res       (res),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Interlock model: configuration and state as they stand after each accepted event
	asi_cfg_t cfg_model = '{gates_present: 1'b1, codec_present: 1'b1,
		arm_ticks: ARM_TICKS_RST, live_ticks: LIVE_TICKS_RST};
	asi_state_t amp_model = '0;

	asi_evt_t event_q[$];
	asi_res_t expected_res_q[$];
	int queued_count = 0;
	int results_seen = 0;
	int mismatch_count = 0;

	// Mute, shut down and end automatic playback, unless there are no gates
	function automatic void drop_to_safe();
		if (cfg_model.gates_present) begin
			amp_model.mute_released = 1'b0;
			amp_model.shdn_released = 1'b0;
			amp_model.play_active = 1'b0;
		end
	endfunction

	function automatic void clear_countdown();
		amp_model.countdown = '0;
		amp_model.countdown_running = 1'b0;
	endfunction

	function automatic void load_countdown(input logic [CountW-1:0] ticks);
		amp_model.countdown = ticks;
		amp_model.countdown_running = 1'b1;
	endfunction

	// Expected result word for one event; updates the model state
	function automatic asi_res_t interlock_next(input asi_evt_t e);
		asi_res_t r;
		r = '0;
		r.status = ST_OK;
		r.codec_action = ACT_NONE;
		if (e.mode == MODE_TICK) begin
			// keepalive countdown; expiry forces safe if either gate is released
			if (amp_model.countdown_running) begin
				if (amp_model.countdown <= 1) begin
					clear_countdown();
					if (amp_model.shdn_released || amp_model.mute_released) begin
						drop_to_safe();
						r.timeout_fired = 1'b1;
					end
				end else begin
					amp_model.countdown = amp_model.countdown - CountW'(1);
				end
			end
		end else if (e.mode == MODE_GATE_OPEN) begin
			if (!cfg_model.gates_present || !e.caller_privileged) begin
				r.status = ST_PERM;
			end else if (amp_model.gate_held) begin
				r.status = ST_BUSY;
			end else begin
				clear_countdown();
				if (amp_model.stream_count != 0) begin
					r.status = ST_BUSY;
				end else begin
					drop_to_safe();
					amp_model.gate_held = 1'b1;
				end
			end
		end else if (e.mode <= MODE_LINE_28DB || e.mode == MODE_UNKNOWN) begin
			// test-gate commands, only while the gate is held
			if (!cfg_model.gates_present || !amp_model.gate_held) begin
				r.status = ST_PERM;
			end else begin
				case (e.mode)
				MODE_GATE_REL: begin
					clear_countdown();
					drop_to_safe();
					amp_model.gate_held = 1'b0;
				end
				MODE_ARM: begin
					clear_countdown();
					drop_to_safe();
					amp_model.shdn_released = 1'b1;
					load_countdown(cfg_model.arm_ticks);
				end
				MODE_UNMUTE: begin
					if (!amp_model.shdn_released || amp_model.mute_released) begin
						r.status = ST_PERM;
					end else begin
						amp_model.mute_released = 1'b1;
						load_countdown(cfg_model.live_ticks);
					end
				end
				MODE_SAFE: begin
					clear_countdown();
					drop_to_safe();
				end
				MODE_KEEPALIVE: begin
					if (!amp_model.mute_released) begin
						r.status = ST_PERM;
					end else begin
						load_countdown(cfg_model.live_ticks);
					end
				end
				MODE_UNKNOWN: begin
					r.status = ST_UNKNOWN;
				end
				default: begin
					// codec commands
					if (!amp_model.mute_released || !cfg_model.codec_present) begin
						r.status = ST_PERM;
					end else begin
						r.codec_action = 3'(e.mode - MODE_DAC_MUTE + 1);
						load_countdown(cfg_model.live_ticks);
					end
				end
				endcase
			end
		end else if (e.mode == MODE_STARTUP) begin
			if (amp_model.gate_held && !e.caller_is_owner) begin
				r.status = ST_BUSY;
			end else if (amp_model.stream_count >= MAX_STREAMS) begin
				r.status = ST_BUSY;
			end else if (e.is_playback && amp_model.play_open) begin
				r.status = ST_BUSY;
			end else begin
				if (e.is_playback) begin
					amp_model.play_open = 1'b1;
					amp_model.play_diagnostic = amp_model.gate_held;
				end
				amp_model.stream_count = amp_model.stream_count + StreamW'(1);
			end
		end else if (e.mode == MODE_PREPARE) begin
			if (e.is_playback && !amp_model.play_diagnostic) begin
				if (amp_model.gate_held) begin
					r.status = ST_BUSY;
				end else begin
					drop_to_safe();
				end
			end
		end else if (e.mode == MODE_TRIGGER) begin
			if (e.is_playback && !amp_model.play_diagnostic) begin
				if (e.trigger_kind == TRIG_START) begin
					// start automatic playback
					if (cfg_model.gates_present && !amp_model.play_active) begin
						if (!amp_model.play_open || amp_model.gate_held) begin
							r.status = ST_BUSY;
						end else begin
							drop_to_safe();
							amp_model.shdn_released = 1'b1;
							amp_model.mute_released = 1'b1;
							amp_model.play_active = 1'b1;
						end
					end
				end else if (e.trigger_kind == TRIG_STOP) begin
					drop_to_safe();
				end else begin
					r.status = ST_BADTRIG;
				end
			end
		end else if (e.mode == MODE_FREE) begin
			if (e.is_playback && !amp_model.play_diagnostic) begin
				drop_to_safe();
			end
		end else if (e.mode == MODE_SHUTDOWN) begin
			if (e.is_playback) begin
				if (!amp_model.play_diagnostic) begin
					drop_to_safe();
				end
				amp_model.play_open = 1'b0;
				amp_model.play_diagnostic = 1'b0;
			end
			if (amp_model.stream_count != 0) begin
				amp_model.stream_count = amp_model.stream_count - StreamW'(1);
			end
		end else if (e.mode == MODE_REMOVE) begin
			if (cfg_model.gates_present) begin
				clear_countdown();
				drop_to_safe();
			end
		end else begin
			r.status = ST_UNKNOWN;
		end
		r.enable_gate = amp_model.shdn_released;
		r.unmute_gate = amp_model.mute_released;
		r.playing = amp_model.play_active;
		return r;
	endfunction

	function automatic int rand_bit();
		return $urandom_range(0, 1);
	endfunction

	task automatic offer(input int mode, input int pb, input int owner, input int priv,
			input int kind);
		asi_evt_t e;
		e.mode = 5'(mode);
		e.is_playback = 1'(pb);
		e.caller_is_owner = 1'(owner);
		e.caller_privileged = 1'(priv);
		e.trigger_kind = 2'(kind);
		event_q.push_back(e);
		queued_count++;
	endtask

	task automatic offer_any(input int mode);
		offer(mode, rand_bit(), rand_bit(), rand_bit(), $urandom_range(0, 3));
	endtask

	// Test-gate session: open, arm, a run of commands, usually a release
	task automatic queue_session();
		offer(MODE_GATE_OPEN, rand_bit(), rand_bit(), ($urandom_range(0, 7) != 0),
			$urandom_range(0, 3));
		if ($urandom_range(0, 5) != 0) begin
			offer_any(MODE_ARM);
		end
		if ($urandom_range(0, 3) != 0) begin
			offer_any(MODE_UNMUTE);
		end
		repeat ($urandom_range(1, 8)) begin
			case ($urandom_range(0, 9))
			0, 1: offer_any(MODE_TICK);
			2: offer_any(MODE_UNMUTE);
			3: offer_any(MODE_KEEPALIVE);
			4, 5: offer_any(MODE_DAC_MUTE + $urandom_range(0, 5));
			6: offer_any(rand_bit() ? MODE_SAFE : MODE_ARM);
			7: offer(MODE_STARTUP, 1, rand_bit(), rand_bit(), $urandom_range(0, 3));
			8: offer(MODE_PREPARE + $urandom_range(0, 3), 1, rand_bit(), rand_bit(),
				$urandom_range(0, 3));
			default: offer_any(rand_bit() ? MODE_UNKNOWN : MODE_GATE_OPEN);
			endcase
		end
		if ($urandom_range(0, 4) != 0) begin
			offer_any(MODE_GATE_REL);
		end
	endtask

	// Playback stream life: startup, prepare, start, ticks, stop, free, shutdown
	task automatic queue_playback();
		if ($urandom_range(0, 3) == 0) begin
			offer(MODE_STARTUP, 0, rand_bit(), rand_bit(), $urandom_range(0, 3));
		end
		offer(MODE_STARTUP, 1, rand_bit(), rand_bit(), $urandom_range(0, 3));
		if (rand_bit()) begin
			offer(MODE_PREPARE, 1, rand_bit(), rand_bit(), $urandom_range(0, 3));
		end
		offer(MODE_TRIGGER, 1, rand_bit(), rand_bit(), TRIG_START);
		repeat ($urandom_range(0, 4)) begin
			offer_any(MODE_TICK);
		end
		offer(MODE_TRIGGER, 1, rand_bit(), rand_bit(),
			($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : TRIG_STOP);
		if (rand_bit()) begin
			offer(MODE_FREE, 1, rand_bit(), rand_bit(), $urandom_range(0, 3));
		end
		if ($urandom_range(0, 5) != 0) begin
			offer(MODE_SHUTDOWN, 1, rand_bit(), rand_bit(), $urandom_range(0, 3));
		end
		if ($urandom_range(0, 3) == 0) begin
			offer(MODE_SHUTDOWN, 0, rand_bit(), rand_bit(), $urandom_range(0, 3));
		end
		if ($urandom_range(0, 7) == 0) begin
			offer_any(MODE_REMOVE);
		end
	endtask

	task automatic queue_random(input int n);
		queued_count = 0;
		while (queued_count < n) begin
			case ($urandom_range(0, 9))
			0, 1, 2: queue_session();
			3, 4, 5: queue_playback();
			6, 7: begin
				repeat ($urandom_range(1, 8)) begin
					offer_any(MODE_TICK);
				end
			end
			default: begin
				repeat ($urandom_range(1, 4)) begin
					offer_any($urandom_range(0, 31));
				end
			end
			endcase
		end
	endtask

	// Edge cases in order, with a short countdown so expiry is reachable
	task automatic queue_directed();
		offer_any(MODE_TICK);
		offer_any(MODE_UNUSED_TOP);
		offer(MODE_ARM, 0, 0, 1, 0);
		offer(MODE_GATE_OPEN, 0, 0, 0, 0);
		offer(MODE_GATE_OPEN, 0, 0, 1, 0);
		offer(MODE_GATE_OPEN, 0, 0, 1, 0);
		offer(MODE_KEEPALIVE, 0, 0, 0, 0);
		offer(MODE_UNMUTE, 0, 0, 0, 0);
		offer(MODE_ARM, 0, 0, 0, 0);
		offer(MODE_UNMUTE, 0, 0, 0, 0);
		for (int m = MODE_DAC_MUTE; m <= MODE_LINE_28DB; m++) begin
			offer(m, 1, 1, 1, 3);
		end
		offer(MODE_UNKNOWN, 0, 0, 0, 0);
		repeat (3) begin
			offer(MODE_TICK, 0, 0, 0, 0);
		end
		offer(MODE_SAFE, 0, 0, 0, 0);
		offer(MODE_GATE_REL, 0, 0, 0, 0);
		offer(MODE_STARTUP, 1, 0, 0, 0);
		offer(MODE_GATE_OPEN, 0, 0, 1, 0);
		repeat (4) begin
			offer(MODE_STARTUP, 0, 0, 0, 0);
		end
		offer(MODE_PREPARE, 0, 0, 0, 0);
		offer(MODE_PREPARE, 1, 0, 0, 0);
		offer(MODE_TRIGGER, 1, 0, 0, TRIG_START);
		offer(MODE_TRIGGER, 1, 0, 0, 2);
		offer(MODE_TRIGGER, 1, 0, 0, TRIG_STOP);
		offer(MODE_FREE, 1, 0, 0, 0);
		repeat (5) begin
			offer(MODE_SHUTDOWN, 1, 0, 0, 0);
		end
		offer(MODE_REMOVE, 0, 0, 0, 0);
	endtask

	// Register write; the model copy follows once the write is taken
	task automatic write_reg(input logic [CfgIndexW-1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CfgDataW-1:0];
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		case (idx)
		REG_GATES_PRESENT: cfg_model.gates_present = val[0];
		REG_CODEC_PRESENT: cfg_model.codec_present = val[0];
		REG_ARM_TICKS: cfg_model.arm_ticks = val[CountW-1:0];
		REG_LIVE_TICKS: cfg_model.live_ticks = val[CountW-1:0];
		endcase
	endtask

	// Sampled on the falling edge so queue and valid are settled
	task automatic wait_drained();
		@(negedge clk);
		while (event_q.size() != 0 || evt_valid || expected_res_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) begin
			@(negedge clk);
		end
	endtask

	// Event driver: bursts of words with random gaps
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid <= 1'b0;
		end else begin
			if (evt_valid && !evt_stall) begin
				expected_res_q.push_back(interlock_next(evt));
			end
			if (!evt_valid || !evt_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					evt_valid <= 1'b0;
				end else if (event_q.size() != 0) begin
					evt <= event_q.pop_front();
					evt_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					evt_valid <= 1'b0;
				end
			end
		end
	end

	task automatic note_mismatch(input string why, input asi_res_t want, input asi_res_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: %s: expected st=%0d en=%0b un=%0b play=%0b act=%0d fire=%0b",
				$realtime, why, want.status, want.enable_gate, want.unmute_gate,
				want.playing, want.codec_action, want.timeout_fired);
			$display("    got st=%0d en=%0b un=%0b play=%0b act=%0d fire=%0b",
				got.status, got.enable_gate, got.unmute_gate, got.playing,
				got.codec_action, got.timeout_fired);
		end
	endtask

	// Result monitor and receiver stall pattern
	asi_res_t want_res;
	int hold_left = 0;
	int next_hold = 40;
	int stall_style = 0;
	int style_left = 50;
	int cyc = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			cyc++;
			if (res_valid && !res_stall) begin
				results_seen++;
				if (expected_res_q.size() == 0) begin
					note_mismatch("word with nothing expected", '0, res);
				end else begin
					want_res = expected_res_q.pop_front();
					if (res.status !== want_res.status
							|| res.enable_gate !== want_res.enable_gate
							|| res.unmute_gate !== want_res.unmute_gate
							|| res.playing !== want_res.playing
							|| res.codec_action !== want_res.codec_action
							|| res.timeout_fired !== want_res.timeout_fired) begin
						note_mismatch("result mismatch", want_res, res);
					end
				end
			end
			// long hold-off now and then so the input side backs up
			if (hold_left != 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (results_seen == next_hold) begin
				hold_left = 120;
				next_hold += 250;
				res_stall <= 1'b1;
			end else begin
				case (stall_style)
				0: res_stall <= 1'b0;
				1: res_stall <= ($urandom_range(0, 9) < 3);
				default: res_stall <= (cyc % 3 == 0);
				endcase
				style_left--;
				if (style_left <= 0) begin
					stall_style = $urandom_range(0, 2);
					style_left = $urandom_range(20, 200);
				end
			end
		end
	end

	// Stimulus phases, each under its own register setting
	initial begin
		repeat (10) begin
			@(posedge clk);
		end
		@(negedge clk);
		arst_n = 1'b1;

		queue_random(100);
		wait_drained();

		write_reg(REG_GATES_PRESENT, 1);
		write_reg(REG_CODEC_PRESENT, 1);
		write_reg(REG_ARM_TICKS, 2);
		write_reg(REG_LIVE_TICKS, 3);
		queue_directed();
		wait_drained();

		write_reg(REG_ARM_TICKS, 1);
		write_reg(REG_LIVE_TICKS, 1);
		queue_random(100);
		wait_drained();

		write_reg(REG_ARM_TICKS, 4095);
		write_reg(REG_LIVE_TICKS, 4095);
		queue_random(80);
		wait_drained();

		write_reg(REG_CODEC_PRESENT, 0);
		write_reg(REG_ARM_TICKS, 6);
		write_reg(REG_LIVE_TICKS, 4);
		queue_random(100);
		wait_drained();

		write_reg(REG_GATES_PRESENT, 0);
		write_reg(REG_CODEC_PRESENT, 1);
		queue_random(80);
		wait_drained();

		write_reg(REG_GATES_PRESENT, 1);
		write_reg(REG_ARM_TICKS, $urandom_range(2, 40));
		write_reg(REG_LIVE_TICKS, $urandom_range(2, 20));
		queue_random(140);
		wait_drained();

		repeat (10) begin
			@(posedge clk);
		end
		if (mismatch_count == 0 && expected_res_q.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
